>>> rtl/mks_pkg.sv
// ----------------------------------------------------------------------------
// mks_pkg: shared types and constants for the motion Kalman smoother
// Fixed path width, config port layout, sequencer states and the request and
// response bundles of the serial add/sub unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mks_pkg;

  localparam int unsigned PATH_W    = 48;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned AXES      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd1;

  typedef enum logic {
    OP_DIV = 1'b0,
    OP_MUL = 1'b1
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_rsp_t;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_PATH = 11'b000_0000_0010,
    ST_PRED = 11'b000_0000_0100,
    ST_GAIN = 11'b000_0000_1000,
    ST_DIV  = 11'b000_0001_0000,
    ST_DIFF = 11'b000_0010_0000,
    ST_MUL1 = 11'b000_0100_0000,
    ST_UPD  = 11'b000_1000_0000,
    ST_MUL2 = 11'b001_0000_0000,
    ST_OUT  = 11'b010_0000_0000,
    ST_DONE = 11'b100_0000_0000
  } state_e;

endpackage

`default_nettype wire

>>> rtl/motion_kalman_smoother.sv
// ----------------------------------------------------------------------------
// motion_kalman_smoother: per-axis scalar Kalman smoothing of frame motion
// Input words are taken only in the idle state, so a new frame is accepted
//   only once the previous result has been loaded into the output register.
//   A held output word stalls the done state until it is taken.
// The single serial add/sub unit runs at most one divide and two multiplies
//   per axis, axes in turn, and none on the first frame after reset.
// Reset: trajectories clear, variances go to 1.0, Q/R to 0.004/0.35, and the
//   next frame only seeds the filter.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_kalman_smoother #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned TDATA_W = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // shift_x, shift_y, turn_angle
  input  wire logic [TDATA_W-1:0]            s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // fixed_shift_x, fixed_shift_y, fixed_turn_angle
  output logic [TDATA_W-1:0]                 m_axis_tdata,
  input  wire logic                          cfg_we_i,
  input  wire logic [mks_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mks_pkg::CFG_W-1:0]     cfg_data_i
);
  import mks_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned PW = PATH_W;
  localparam int unsigned KW = FRAC_BITS + 1;
  localparam int unsigned AW = PW + FRAC_BITS + 1;
  localparam int unsigned SW = ((DW > CFG_W) ? DW : CFG_W) + 1;

  localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
  localparam logic [CFG_W-1:0] Q_RST = CFG_W'((ONE_L * 4 + 500) / 1000);
  localparam logic [CFG_W-1:0] R_RST = CFG_W'((ONE_L * 35 + 50) / 100);

  localparam logic [KW-1:0] ONE_K   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [DW-1:0] VAR_MAX = {DW{1'b1}};
  localparam logic [DW-1:0] VAR_ONE = (FRAC_BITS >= DATA_WIDTH) ? VAR_MAX :
                                      ({{(DW-1){1'b0}}, 1'b1} << FRAC_BITS);
  localparam logic [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};
  localparam logic [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  state_e        state_q, state_d;
  logic [1:0]    ax_q, ax_d;
  logic          first_q, first_d;
  logic          m_valid_q, m_valid_d;
  logic [CFG_W-1:0] qn_q, qn_d, rn_q, rn_d;
  logic [DW-1:0] in_q [AXES];
  logic [DW-1:0] in_d [AXES];
  logic [PW-1:0] path_q [AXES];
  logic [PW-1:0] path_d [AXES];
  logic [PW-1:0] smooth_q [AXES];
  logic [PW-1:0] smooth_d [AXES];
  logic [DW-1:0] var_q [AXES];
  logic [DW-1:0] var_d [AXES];
  logic [DW-1:0] res_q [AXES];
  logic [DW-1:0] res_d [AXES];
  logic [DW-1:0] out_q [AXES];
  logic [DW-1:0] out_d [AXES];
  logic [DW-1:0] pp_q, pp_d;
  logic [SW-1:0] den_q, den_d;
  logic [KW-1:0] k_q, k_d;
  logic          neg_q, neg_d;

  unit_req_t     unit_req;
  unit_rsp_t     unit_rsp;
  logic [AW-1:0] unit_opb, unit_acc;
  logic [KW-1:0] unit_mult, unit_quo;

  logic [DW-1:0]   d_cur, var_cur;
  logic [PW-1:0]   path_cur, smooth_cur, path_new, diff_s, mag, term, smooth_new;
  logic [PW:0]     path_w, diff_w;
  logic [SW-1:0]   pq_sum;
  logic [DW-1:0]   pp_new;
  logic [PW+1:0]   up_w, o_w;
  logic [PW+2-DW:0] o_top;
  logic [DW-1:0]   res_new;

  mks_serial_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .opa_i  (AW'(pp_q)),
    .opb_i  (unit_opb),
    .mult_i (unit_mult),
    .rsp_o  (unit_rsp),
    .acc_o  (unit_acc),
    .quo_o  (unit_quo)
  );

  // datapath
  always_comb begin
    d_cur      = in_q[ax_q];
    path_cur   = path_q[ax_q];
    smooth_cur = smooth_q[ax_q];
    var_cur    = var_q[ax_q];

    path_w = {path_cur[PW-1], path_cur} + {{(PW+1-DW){d_cur[DW-1]}}, d_cur};
    if (path_w[PW] != path_w[PW-1]) begin
      path_new = path_w[PW] ? PMIN : PMAX;
    end else begin
      path_new = path_w[PW-1:0];
    end

    pq_sum = SW'(var_cur) + SW'(qn_q);
    pp_new = (pq_sum > SW'(VAR_MAX)) ? VAR_MAX : pq_sum[DW-1:0];

    diff_w = {path_cur[PW-1], path_cur} - {smooth_cur[PW-1], smooth_cur};
    if (diff_w[PW] != diff_w[PW-1]) begin
      diff_s = diff_w[PW] ? PMIN : PMAX;
    end else begin
      diff_s = diff_w[PW-1:0];
    end
    mag = diff_s[PW-1] ? (~diff_s + 1'b1) : diff_s;

    term = unit_acc[FRAC_BITS +: PW];
    if (neg_q) begin
      up_w = {{2{smooth_cur[PW-1]}}, smooth_cur} - {2'b00, term};
    end else begin
      up_w = {{2{smooth_cur[PW-1]}}, smooth_cur} + {2'b00, term};
    end
    if (!((&up_w[PW+1:PW-1]) || !(|up_w[PW+1:PW-1]))) begin
      smooth_new = up_w[PW+1] ? PMIN : PMAX;
    end else begin
      smooth_new = up_w[PW-1:0];
    end

    o_w = {{(PW+2-DW){d_cur[DW-1]}}, d_cur} + {{2{smooth_cur[PW-1]}}, smooth_cur}
        - {{2{path_cur[PW-1]}}, path_cur};
    o_top = o_w[PW+1:DW-1];
    if (!((&o_top) || !(|o_top))) begin
      res_new = o_w[PW+1] ? DMIN : DMAX;
    end else begin
      res_new = o_w[DW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    ax_d      = ax_q;
    first_d   = first_q;
    m_valid_d = m_valid_q;
    qn_d      = qn_q;
    rn_d      = rn_q;
    in_d      = in_q;
    path_d    = path_q;
    smooth_d  = smooth_q;
    var_d     = var_q;
    res_d     = res_q;
    out_d     = out_q;
    pp_d      = pp_q;
    den_d     = den_q;
    k_d       = k_q;
    neg_d     = neg_q;
    unit_req.start = 1'b0;
    unit_req.op    = OP_DIV;
    unit_opb  = AW'(den_q);
    unit_mult = k_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PROC_NOISE: qn_d = cfg_data_i;
        REG_MEAS_NOISE: rn_d = cfg_data_i;
        default: ;
      endcase
    end

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          for (int i = 0; i < AXES; i++) begin
            in_d[i] = s_axis_tdata[i*DW +: DW];
          end
          ax_d    = 2'd0;
          state_d = ST_PATH;
        end
      end
      ST_PATH: begin
        path_d[ax_q] = path_new;
        if (first_q) begin
          smooth_d[ax_q] = '0;
          var_d[ax_q]    = VAR_ONE;
          state_d        = ST_OUT;
        end else begin
          state_d = ST_PRED;
        end
      end
      ST_PRED: begin
        pp_d    = pp_new;
        den_d   = SW'(pp_new) + SW'(rn_q);
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        if (den_q == '0) begin
          k_d     = '0;
          state_d = ST_DIFF;
        end else if (SW'(pp_q) >= den_q) begin
          k_d     = ONE_K;
          state_d = ST_DIFF;
        end else begin
          unit_req.start = 1'b1;
          unit_req.op    = OP_DIV;
          unit_opb       = AW'(den_q);
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        if (unit_rsp.done) begin
          k_d     = {1'b0, unit_quo[FRAC_BITS-1:0]};
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        neg_d          = diff_s[PW-1];
        unit_req.start = 1'b1;
        unit_req.op    = OP_MUL;
        unit_opb       = AW'(mag);
        unit_mult      = k_q;
        state_d        = ST_MUL1;
      end
      ST_MUL1: begin
        if (unit_rsp.done) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        smooth_d[ax_q] = smooth_new;
        unit_req.start = 1'b1;
        unit_req.op    = OP_MUL;
        unit_opb       = AW'(pp_q);
        unit_mult      = ONE_K - k_q;
        state_d        = ST_MUL2;
      end
      ST_MUL2: begin
        if (unit_rsp.done) begin
          var_d[ax_q] = unit_acc[FRAC_BITS +: DW];
          state_d     = ST_OUT;
        end
      end
      ST_OUT: begin
        res_d[ax_q] = res_new;
        if (ax_q == 2'(AXES - 1)) begin
          state_d = ST_DONE;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = ST_PATH;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_d     = res_q;
          m_valid_d = 1'b1;
          first_d   = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ax_q      <= 2'd0;
      first_q   <= 1'b1;
      m_valid_q <= 1'b0;
      qn_q      <= Q_RST;
      rn_q      <= R_RST;
      for (int i = 0; i < AXES; i++) begin
        path_q[i]   <= '0;
        smooth_q[i] <= '0;
        var_q[i]    <= VAR_ONE;
      end
    end else begin
      state_q   <= state_d;
      ax_q      <= ax_d;
      first_q   <= first_d;
      m_valid_q <= m_valid_d;
      qn_q      <= qn_d;
      rn_q      <= rn_d;
      path_q    <= path_d;
      smooth_q  <= smooth_d;
      var_q     <= var_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    res_q <= res_d;
    out_q <= out_d;
    pp_q  <= pp_d;
    den_q <= den_d;
    k_q   <= k_d;
    neg_q <= neg_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = TDATA_W'({out_q[2], out_q[1], out_q[0]});

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_req.start |-> !unit_rsp.busy)
    else $error("serial unit started while busy");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIFF) |-> (k_q <= ONE_K))
    else $error("gain above 1.0");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("output word raised outside done state");

  a_first_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(first_q) |-> m_valid_q)
    else $error("first-frame flag cleared without an output word");

endmodule

`default_nettype wire

>>> rtl/mks_serial_unit.sv
// ----------------------------------------------------------------------------
// mks_serial_unit: shared shift-add / shift-subtract unit
// One adder per cycle. Divide: restoring division, one quotient bit per step,
// FRAC_BITS steps. Multiply: MSB-first shift-add over FRAC_BITS+1 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mks_serial_unit #(
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned AW = mks_pkg::PATH_W + FRAC_BITS + 1,
  localparam int unsigned KW = FRAC_BITS + 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mks_pkg::unit_req_t req_i,
  input  wire logic [AW-1:0]      opa_i,   // dividend
  input  wire logic [AW-1:0]      opb_i,   // divisor or multiplicand
  input  wire logic [KW-1:0]      mult_i,  // multiplier
  output mks_pkg::unit_rsp_t      rsp_o,
  output logic [AW-1:0]           acc_o,   // product
  output logic [KW-1:0]           quo_o    // quotient
);
  import mks_pkg::*;

  localparam int unsigned CW = $clog2(KW + 1);

  logic [AW-1:0] acc_q, acc_d, b_q, b_d;
  logic [KW-1:0] k_q, k_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  unit_op_e      op_q, op_d;
  logic [AW-1:0] shifted;
  logic [AW:0]   addend, sum;
  logic          fits;

  always_comb begin
    shifted = {acc_q[AW-2:0], 1'b0};
    if (op_q == OP_DIV) begin
      addend = ~{1'b0, b_q};
    end else begin
      addend = k_q[KW-1] ? {1'b0, b_q} : '0;
    end
    sum  = {1'b0, shifted} + addend + {{AW{1'b0}}, (op_q == OP_DIV)};
    fits = ~sum[AW];
  end

  always_comb begin
    acc_d  = acc_q;
    b_d    = b_q;
    k_d    = k_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    op_d   = op_q;
    done_d = 1'b0;
    if (req_i.start) begin
      op_d   = req_i.op;
      b_d    = opb_i;
      busy_d = 1'b1;
      if (req_i.op == OP_DIV) begin
        acc_d = opa_i;
        k_d   = '0;
        cnt_d = CW'(FRAC_BITS);
      end else begin
        acc_d = '0;
        k_d   = mult_i;
        cnt_d = CW'(KW);
      end
    end else if (busy_q) begin
      if (op_q == OP_DIV) begin
        acc_d = fits ? sum[AW-1:0] : shifted;
        k_d   = {k_q[KW-2:0], fits};
      end else begin
        acc_d = sum[AW-1:0];
        k_d   = {k_q[KW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_DIV;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
    k_q   <= k_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign acc_o      = acc_q;
  assign quo_o      = k_q;

endmodule

`default_nettype wire

>>> tb/motion_kalman_smoother_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_kalman_smoother_tb: self-checking bench for the motion smoother
// Drives motion words (x shift, y shift, angle) over the input stream and
// checks every corrected word against a bit-exact per-axis Kalman predictor.
// A directed table covers seeding, gain of one, zero denominator and variance
// overflow; random phases then sweep Q/R settings with bursty input, random
// output stalls and one long output hold-off.
// ----------------------------------------------------------------------------

module motion_kalman_smoother_tb;
  import mks_pkg::*;

  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int TDATA_W = ((3 * DATA_W + 7) / 8) * 8;

  localparam longint ONE_Q   = longint'(1) << FRAC_W;
  localparam longint VAR_MAX = (longint'(1) << DATA_W) - 1;

  // unmapped register indexes, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam logic [31:0] Q_DEF = 32'd262;
  localparam logic [31:0] R_DEF = 32'd22938;
  localparam logic [31:0] N_MAX = 32'hFFFF_FFFF;

  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

  localparam int NUM_DIRECTED = 20;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 160;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 900;
  localparam int DRAIN_CYCLES = 250;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] turn;
    logic signed [DATA_W-1:0] sy;
    logic signed [DATA_W-1:0] sx;
  } motion_t;

  typedef struct packed {
    logic                     set_noise;
    logic [31:0]              q;
    logic [31:0]              r;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] a;
    logic                     typed;
    logic signed [DATA_W-1:0] ex;
    logic signed [DATA_W-1:0] ey;
    logic signed [DATA_W-1:0] ea;
  } stim_row_t;

  // set_noise, Q, R, x, y, angle, typed, expected x, y, angle
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    // first frame only seeds: corrected motion is zero
    '{1'b0, Q_DEF, R_DEF, S_MAX, S_MIN, 32'sd1, 1'b1, 32'sd0, 32'sd0, 32'sd0},
    '{1'b0, Q_DEF, R_DEF, S_MIN, S_MAX, -32'sd1, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{1'b0, Q_DEF, R_DEF, 32'sd0, 32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{1'b0, Q_DEF, R_DEF, S_MAX, S_MAX, S_MAX, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{1'b0, Q_DEF, R_DEF, S_MIN, S_MIN, S_MIN, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{1'b0, Q_DEF, R_DEF, 32'sd65536, -32'sd32768, 32'sd205887, 1'b0,
      32'sd0, 32'sd0, 32'sd0},
    // R = 0: gain is exactly one, motion passes through
    '{1'b1, Q_DEF, 32'd0, 32'sd12345, -32'sd777, S_MAX, 1'b1,
      32'sd12345, -32'sd777, S_MAX},
    '{1'b0, Q_DEF, 32'd0, S_MIN, 32'sd1, -32'sd1, 1'b1, S_MIN, 32'sd1, -32'sd1},
    // Q = R = 0 with P = 0: zero denominator, gain zero
    '{1'b1, 32'd0, 32'd0, 32'sd1000000, -32'sd1000000, 32'sd3, 1'b0,
      32'sd0, 32'sd0, 32'sd0},
    '{1'b0, 32'd0, 32'd0, S_MAX, S_MIN, 32'sd0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    // full-scale Q, R = 0: gain one again
    '{1'b1, N_MAX, 32'd0, -32'sd5, 32'sd6, -32'sd7, 1'b1, -32'sd5, 32'sd6, -32'sd7},
    // full-scale Q and R: P + Q saturates on the next frame
    '{1'b1, N_MAX, N_MAX, S_MAX, S_MAX, S_MIN, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{1'b0, N_MAX, N_MAX, S_MIN, S_MIN, S_MAX, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{1'b1, 32'd0, N_MAX, S_MAX, S_MAX, S_MAX, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{1'b0, 32'd0, N_MAX, S_MAX, S_MAX, S_MAX, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{1'b0, 32'd0, N_MAX, S_MIN, S_MIN, S_MIN, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{1'b0, 32'd0, N_MAX, 32'sh1234_5678, -32'sh1234_5678, 32'sh5555_AAAA, 1'b0,
      32'sd0, 32'sd0, 32'sd0},
    '{1'b1, Q_DEF, R_DEF, 32'sd32768, -32'sd32768, 32'sd1, 1'b0,
      32'sd0, 32'sd0, 32'sd0},
    '{1'b0, Q_DEF, R_DEF, S_MIN, S_MIN, S_MIN, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{1'b0, Q_DEF, R_DEF, S_MAX, -32'sd1, 32'shAAAA_5555, 1'b0,
      32'sd0, 32'sd0, 32'sd0}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // shift_x, shift_y, turn_angle
  logic [TDATA_W-1:0]   s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // fixed_shift_x, fixed_shift_y, fixed_turn_angle
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  motion_kalman_smoother uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // smoother model state
  longint path_acc [AXES];
  longint smooth_acc [AXES];
  longint err_var [AXES];
  bit     seed_pending;
  longint q_noise;
  longint r_noise;

  motion_t corrected_due [$];
  int      frames_sent;
  int      words_checked;
  int      mismatches;
  int      settings_used;
  int      spare_writes;
  int      burst_left;
  bit      steady;
  int      drift;
  string   axis_label [AXES] = '{"fixed_shift_x", "fixed_shift_y", "fixed_turn_angle"};

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #25_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // floor(mag * k / 2^FRAC)
  function automatic longint scale_q(longint mag, longint k);
    return (mag >> FRAC_W) * k + (((mag & (ONE_Q - 1)) * k) >> FRAC_W);
  endfunction

  // restoring division, FRAC_W quotient bits
  function automatic longint kalman_gain(longint p, longint d);
    longint quo;
    longint rem;
    int     i;
    quo = 0;
    rem = p;
    if (d == 0) return 0;
    if (p >= d) return ONE_Q;
    for (i = 0; i < FRAC_W; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= d) begin
        rem = rem - d;
        quo = quo | 1;
      end
    end
    return quo;
  endfunction

  function automatic void reset_model();
    int i;
    for (i = 0; i < AXES; i++) begin
      path_acc[i]   = 0;
      smooth_acc[i] = 0;
      err_var[i]    = ONE_Q;
    end
    seed_pending = 1'b1;
    q_noise = longint'(Q_DEF);
    r_noise = longint'(R_DEF);
  endfunction

  function automatic motion_t smooth_frame(motion_t m);
    logic [TDATA_W-1:0] inv;
    logic [TDATA_W-1:0] outv;
    longint d, pp, k, diff, mag, term, corr;
    int     i;
    inv  = m;
    outv = '0;
    for (i = 0; i < AXES; i++) begin
      d = longint'($signed(inv[i*DATA_W +: DATA_W]));
      path_acc[i] = clamp(path_acc[i] + d, PATH_W);
      if (seed_pending) begin
        smooth_acc[i] = 0;
        err_var[i]    = ONE_Q;
      end else begin
        pp = err_var[i] + q_noise;
        if (pp > VAR_MAX) pp = VAR_MAX;
        k    = kalman_gain(pp, pp + r_noise);
        diff = clamp(path_acc[i] - smooth_acc[i], PATH_W);
        mag  = (diff < 0) ? -diff : diff;
        term = scale_q(mag, k);
        if (diff < 0) smooth_acc[i] = clamp(smooth_acc[i] - term, PATH_W);
        else smooth_acc[i] = clamp(smooth_acc[i] + term, PATH_W);
        err_var[i] = scale_q(pp, ONE_Q - k);
      end
      corr = clamp(d + smooth_acc[i] - path_acc[i], DATA_W);
      outv[i*DATA_W +: DATA_W] = corr[DATA_W-1:0];
    end
    seed_pending = 1'b0;
    return motion_t'(outv);
  endfunction

  function automatic logic signed [31:0] rand_axis();
    int jitter;
    int sel;
    jitter = int'($urandom_range(0, 32'd2097152)) - 1048576;
    sel = $urandom_range(0, 99);
    if (sel < 45) return jitter;
    if (sel < 65) return drift + jitter / 16;
    if (sel < 85) return $urandom();
    if (sel < 95) begin
      case ($urandom_range(0, 4))
        0: return S_MAX;
        1: return S_MIN;
        2: return 32'sd0;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    return ($urandom_range(0, 1) ? 32'sh4000_0000 : 32'shC000_0000) + jitter;
  endfunction

  // append one expected word at the tail of the scoreboard
  function automatic void queue_word(motion_t w);
    corrected_due.insert(corrected_due.size(), w);
  endfunction

  task automatic program_noise(logic [31:0] q, logic [31:0] r);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = REG_PROC_NOISE;
    cfg_data_i = q;
    @(negedge clk_i);
    cfg_idx_i  = REG_MEAS_NOISE;
    cfg_data_i = r;
    @(negedge clk_i);
    cfg_idx_i  = REG_SPARE_2;
    cfg_data_i = $urandom();
    @(negedge clk_i);
    cfg_idx_i  = REG_SPARE_3;
    cfg_data_i = $urandom();
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    q_noise = longint'(q);
    r_noise = longint'(r);
    settings_used++;
    spare_writes += 2;
  endtask

  // drop valid and wait until every corrected word is back
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (corrected_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_frame(motion_t m, bit typed, motion_t want);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      if (steady) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(0, 220);
      else gap = $urandom_range(0, 4);
      if (gap != 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = m;
    do @(posedge clk_i); while (!s_axis_tready);
    if (typed) begin
      void'(smooth_frame(m));
      queue_word(want);
    end else begin
      queue_word(smooth_frame(m));
    end
    frames_sent++;
  endtask

  initial begin : stimulus
    stim_row_t row;
    motion_t   m;
    int        n;
    int        p;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_PROC_NOISE;
    cfg_data_i    = '0;
    frames_sent   = 0;
    words_checked = 0;
    mismatches    = 0;
    settings_used = 0;
    spare_writes  = 0;
    burst_left    = 0;
    steady        = 1'b0;
    drift         = 0;
    reset_model();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (n = 0; n < NUM_DIRECTED; n++) begin
      row = DIRECTED[n];
      if (row.set_noise) begin
        settle();
        program_noise(row.q, row.r);
      end
      send_frame({row.a, row.y, row.x}, row.typed, {row.ea, row.ey, row.ex});
    end

    for (p = 0; p < RAND_PHASES; p++) begin
      settle();
      case (p)
        0: program_noise(Q_DEF, R_DEF);
        1: program_noise(32'd0, 32'd0);
        2: program_noise(N_MAX, N_MAX);
        3: program_noise(32'd0, N_MAX);
        4: program_noise(N_MAX, 32'd0);
        5: program_noise($urandom_range(0, 4096), $urandom_range(0, 32'h10_0000));
        6: program_noise($urandom(), $urandom());
        7: program_noise($urandom_range(0, 65536), 32'd0);
        8: program_noise(32'd0, $urandom_range(1, 255));
        default: program_noise($urandom_range(0, 32'h4_0000), $urandom_range(0, 32'h4_0000));
      endcase
      drift  = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
      steady = ($urandom_range(0, 2) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        m = {rand_axis(), rand_axis(), rand_axis()};
        send_frame(m, 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d frames (%0d directed) over %0d Q/R settings, incl. zero and full scale",
             frames_sent, NUM_DIRECTED, settings_used);
    $display("%0d words checked, %0d unmapped register writes, %0d mismatches",
             words_checked, spare_writes, mismatches);
    if (mismatches == 0 && corrected_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // output sink: stall pattern drawn at random from five modes, one long hold-off
  initial begin : sink
    int cyc;
    int mode;
    bit held;
    m_axis_tready = 1'b0;
    cyc  = 0;
    mode = 0;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!held && frames_sent >= HOLD_AT) begin
        held = 1'b1;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (cyc % 256 == 0) mode = $urandom_range(0, 4);
      case (mode)
        0: m_axis_tready = 1'b1;
        1: m_axis_tready = 1'($urandom_range(0, 1));
        2: m_axis_tready = 1'(8'b1011_0010 >> (cyc % 8));
        3: m_axis_tready = ($urandom_range(0, 3) == 0);
        default: m_axis_tready = (cyc % 64) >= 40;
      endcase
      cyc++;
    end
  end

  always @(posedge clk_i) begin : check_output
    logic [TDATA_W-1:0] got;
    logic [TDATA_W-1:0] want;
    int                 i;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (corrected_due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("word %0d arrived with nothing expected: %h", words_checked, got);
        mismatches++;
      end else begin
        want = corrected_due.pop_front();
        for (i = 0; i < AXES; i++) begin
          if (got[i*DATA_W +: DATA_W] !== want[i*DATA_W +: DATA_W]) begin
            if (mismatches < MAX_REPORTS)
              $display("word %0d %s: expected %0d, got %0d", words_checked, axis_label[i],
                       $signed(want[i*DATA_W +: DATA_W]), $signed(got[i*DATA_W +: DATA_W]));
            mismatches++;
          end
        end
      end
      words_checked++;
    end
  end

endmodule
